// ===== rtl/ssht_pkg.sv =====
// Shared types, widths and codes for the segment and sphere hit test pipeline.
package ssht_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned DOT_W     = PROD_W + 2;
  localparam int unsigned LEN_W     = PROD_W;
  localparam int unsigned RAD_W     = 31;
  localparam int unsigned RR_W      = 2 * RAD_W;
  localparam int unsigned DIV_STEPS = DIFF_W;

  localparam int unsigned ST_A       = 0;
  localparam int unsigned ST_B       = 1;
  localparam int unsigned ST_C       = 2;
  localparam int unsigned ST_DIV0    = 3;
  localparam int unsigned ST_DIVN    = ST_DIV0 + DIV_STEPS;
  localparam int unsigned ST_E       = ST_DIVN + 1;
  localparam int unsigned ST_F       = ST_E + 1;
  localparam int unsigned ST_G       = ST_F + 1;
  localparam int unsigned NUM_STAGES = ST_G + 1;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_MID   = 2'd2;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] s;
    logic [2:0][COORD_W-1:0] e;
    logic [2:0][COORD_W-1:0] b;
    logic [RR_W-1:0]         rr;
  } side_t;

endpackage

// ===== rtl/segment_sphere_hit_test.sv =====
// Pipelined closest point on a segment to a sphere centre, with hit flag.
// One query is taken in every clock cycle while in_stall is low. The pipeline has 40
// register stages. Three form the differences, products and dot sums. One classifies the
// projection. The divider that forms the projection offset then produces one
// quotient digit (0, 1 or 2) per stage for 33 stages. Three more select the near point,
// square the distances and compare against the squared radius. A stall on the output
// holds only the stages that are full, so bubbles close up and no transfer is lost or
// repeated.
module segment_sphere_hit_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] start_x,
  input  logic [31:0] start_y,
  input  logic [31:0] start_z,
  input  logic [31:0] end_x,
  input  logic [31:0] end_y,
  input  logic [31:0] end_z,
  input  logic [31:0] ball_x,
  input  logic [31:0] ball_y,
  input  logic [31:0] ball_z,
  input  logic [30:0] radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] near_x,
  output logic [31:0] near_y,
  output logic [31:0] near_z
);

  logic [ssht_pkg::NUM_STAGES-1:0] v;
  logic [ssht_pkg::NUM_STAGES:0]   rdy;

  assign rdy[ssht_pkg::NUM_STAGES] = !out_stall;
  for (genvar i = 0; i < ssht_pkg::NUM_STAGES; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < ssht_pkg::NUM_STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[ssht_pkg::ST_G];

  // Stage A: register the item, form d = end - start and w = ball - start.
  ssht_pkg::side_t          a_side;
  logic signed [32:0]       a_d [3];
  logic signed [32:0]       a_w [3];
  logic [30:0]              a_r;
  logic [2:0][31:0]         in_s, in_e, in_b;

  assign in_s = {start_z, start_y, start_x};
  assign in_e = {end_z, end_y, end_x};
  assign in_b = {ball_z, ball_y, ball_x};

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_A]) begin
      a_side.s  <= in_s;
      a_side.e  <= in_e;
      a_side.b  <= in_b;
      a_side.rr <= '0;
      a_r       <= radius;
      for (int c = 0; c < 3; c++) begin
        a_d[c] <= $signed({in_e[c][31], in_e[c]}) - $signed({in_s[c][31], in_s[c]});
        a_w[c] <= $signed({in_b[c][31], in_b[c]}) - $signed({in_s[c][31], in_s[c]});
      end
    end
  end

  // Stage B: products d.w per axis, d squared per axis and radius squared.
  ssht_pkg::side_t          b_side;
  logic signed [32:0]       b_d  [3];
  logic signed [65:0]       b_dw [3];
  logic signed [65:0]       b_dd [3];

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_B]) begin
      b_side.s  <= a_side.s;
      b_side.e  <= a_side.e;
      b_side.b  <= a_side.b;
      b_side.rr <= 62'(a_r * a_r);
      for (int c = 0; c < 3; c++) begin
        b_d[c]  <= a_d[c];
        b_dw[c] <= a_d[c] * a_w[c];
        b_dd[c] <= a_d[c] * a_d[c];
      end
    end
  end

  // Stage C: t = d.w and L = |d|^2.
  ssht_pkg::side_t          c_side;
  logic signed [32:0]       c_d [3];
  logic signed [67:0]       c_t;
  logic [65:0]              c_l;

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_C]) begin
      c_side <= b_side;
      c_d    <= b_d;
      c_t    <= 68'(b_dw[0]) + 68'(b_dw[1]) + 68'(b_dw[2]);
      c_l    <= 66'(b_dd[0]) + 66'(b_dd[1]) + 66'(b_dd[2]);
    end
  end

  // Divider stages: entry zero classifies the projection, each later entry
  // forms one quotient digit (0, 1 or 2) of |d|*t/L per axis.
  ssht_pkg::side_t q_side [ssht_pkg::DIV_STEPS+1];
  logic [1:0]      q_mode [ssht_pkg::DIV_STEPS+1];
  logic [2:0]      q_neg  [ssht_pkg::DIV_STEPS+1];
  logic [32:0]     q_m    [ssht_pkg::DIV_STEPS+1][3];
  logic [65:0]     q_t    [ssht_pkg::DIV_STEPS+1];
  logic [65:0]     q_l    [ssht_pkg::DIV_STEPS+1];
  logic [65:0]     q_r    [ssht_pkg::DIV_STEPS+1][3];
  logic [32:0]     q_q    [ssht_pkg::DIV_STEPS+1][3];

  logic [1:0]      mode_next;

  always_comb begin
    if (c_t[67] || c_t == '0) begin
      mode_next = ssht_pkg::MODE_START;
    end else if (c_t >= $signed({2'b00, c_l})) begin
      mode_next = ssht_pkg::MODE_END;
    end else begin
      mode_next = ssht_pkg::MODE_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_DIV0]) begin
      q_side[0] <= c_side;
      q_mode[0] <= mode_next;
      q_t[0]    <= c_t[65:0];
      q_l[0]    <= c_l;
      for (int c = 0; c < 3; c++) begin
        q_neg[0][c] <= c_d[c][32];
        q_m[0][c]   <= c_d[c][32] ? 33'(-c_d[c]) : 33'(c_d[c]);
        q_r[0][c]   <= '0;
        q_q[0][c]   <= '0;
      end
    end
  end

  for (genvar k = 1; k <= ssht_pkg::DIV_STEPS; k++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [67:0] sum2;
      logic [67:0] lsum;
      logic [67:0] l2sum;
      logic [65:0] r_next;
      logic [32:0] q_next;

      always_comb begin
        sum2   = {1'b0, q_r[k-1][c], 1'b0}
               + (q_m[k-1][c][ssht_pkg::DIV_STEPS-k] ? {2'b00, q_t[k-1]} : 68'd0);
        lsum   = {2'b00, q_l[k-1]};
        l2sum  = {1'b0, q_l[k-1], 1'b0};
        q_next = {q_q[k-1][c][31:0], 1'b0};
        if (sum2 >= l2sum) begin
          r_next = 66'(sum2 - l2sum);
          q_next = q_next + 33'd2;
        end else if (sum2 >= lsum) begin
          r_next = 66'(sum2 - lsum);
          q_next = q_next + 33'd1;
        end else begin
          r_next = sum2[65:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[ssht_pkg::ST_DIV0+k]) begin
          q_r[k][c] <= r_next;
          q_q[k][c] <= q_next;
          q_m[k][c] <= q_m[k-1][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ssht_pkg::ST_DIV0+k]) begin
        q_side[k] <= q_side[k-1];
        q_mode[k] <= q_mode[k-1];
        q_neg[k]  <= q_neg[k-1];
        q_t[k]    <= q_t[k-1];
        q_l[k]    <= q_l[k-1];
      end
    end
  end

  // Stage E: select the near point and its offset from the centre.
  logic [31:0]        e_near [3];
  logic signed [32:0] e_diff [3];
  logic [61:0]        e_rr;
  logic [31:0]        near_next [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (q_mode[ssht_pkg::DIV_STEPS])
        ssht_pkg::MODE_START: near_next[c] = q_side[ssht_pkg::DIV_STEPS].s[c];
        ssht_pkg::MODE_END:   near_next[c] = q_side[ssht_pkg::DIV_STEPS].e[c];
        default: begin
          if (q_neg[ssht_pkg::DIV_STEPS][c]) begin
            near_next[c] = q_side[ssht_pkg::DIV_STEPS].s[c]
                         - q_q[ssht_pkg::DIV_STEPS][c][31:0];
          end else begin
            near_next[c] = q_side[ssht_pkg::DIV_STEPS].s[c]
                         + q_q[ssht_pkg::DIV_STEPS][c][31:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_E]) begin
      e_rr <= q_side[ssht_pkg::DIV_STEPS].rr;
      for (int c = 0; c < 3; c++) begin
        e_near[c] <= near_next[c];
        e_diff[c] <= $signed({q_side[ssht_pkg::DIV_STEPS].b[c][31],
                              q_side[ssht_pkg::DIV_STEPS].b[c]})
                   - $signed({near_next[c][31], near_next[c]});
      end
    end
  end

  // Stage F: squared distance per axis.
  logic [31:0]        f_near [3];
  logic signed [65:0] f_sq   [3];
  logic [61:0]        f_rr;

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_F]) begin
      f_rr   <= e_rr;
      f_near <= e_near;
      for (int c = 0; c < 3; c++) begin
        f_sq[c] <= e_diff[c] * e_diff[c];
      end
    end
  end

  // Stage G: output register.
  logic [65:0] dist_sq;

  assign dist_sq = 66'(f_sq[0]) + 66'(f_sq[1]) + 66'(f_sq[2]);

  always_ff @(posedge clk) begin
    if (rdy[ssht_pkg::ST_G]) begin
      hit    <= {4'b0000, f_rr} >= dist_sq;
      near_x <= f_near[0];
      near_y <= f_near[1];
      near_z <= f_near[2];
    end
  end

  // A full pipeline with a stalled output must push back on the input.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (&v && out_stall) |-> in_stall)
    else $error("full pipeline did not stall the input");

  // The first stage only fills from an accepted transfer.
  a_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(v[ssht_pkg::ST_A]) |-> $past(in_valid && !in_stall))
    else $error("first stage filled without a transfer");

  // The divider remainder stays below L on the interior case.
  a_rem : assert property (@(posedge clk) disable iff (rst)
    (v[ssht_pkg::ST_DIVN] && q_mode[ssht_pkg::DIV_STEPS] == ssht_pkg::MODE_MID) |->
    (q_r[ssht_pkg::DIV_STEPS][0] < q_l[ssht_pkg::DIV_STEPS] &&
     q_r[ssht_pkg::DIV_STEPS][1] < q_l[ssht_pkg::DIV_STEPS] &&
     q_r[ssht_pkg::DIV_STEPS][2] < q_l[ssht_pkg::DIV_STEPS]))
    else $error("divider remainder out of range");

  // An interior offset never exceeds the full segment length on any axis.
  a_quot : assert property (@(posedge clk) disable iff (rst)
    (v[ssht_pkg::ST_DIVN] && q_mode[ssht_pkg::DIV_STEPS] == ssht_pkg::MODE_MID) |->
    (q_q[ssht_pkg::DIV_STEPS][0] <= q_m[ssht_pkg::DIV_STEPS][0] &&
     q_q[ssht_pkg::DIV_STEPS][1] <= q_m[ssht_pkg::DIV_STEPS][1] &&
     q_q[ssht_pkg::DIV_STEPS][2] <= q_m[ssht_pkg::DIV_STEPS][2]))
    else $error("projection offset beyond segment end");

endmodule

// ===== verif/segment_sphere_hit_test_test.sv =====
// Self-checking testbench for the segment and sphere hit test pipeline.
`timescale 1ns / 1ps
module segment_sphere_hit_test_test;

  localparam int HOLD_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic        hit;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } nearest_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic [31:0] ball_x = '0, ball_y = '0, ball_z = '0;
  logic [30:0] radius = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [31:0] near_x, near_y, near_z;

  nearest_t pending_hits[$];
  int       error_count = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_output = 1'b0;
  bit       hold_active = 1'b0;

  segment_sphere_hit_test u_top (.*);

  always #2 clk = ~clk;

  function automatic nearest_t nearest_point(logic [31:0] s[3], logic [31:0] e[3],
                                             logic [31:0] b[3], logic [30:0] rad);
    logic signed [33:0]  d[3], w[3];
    logic signed [127:0] t, len, num, q, dist_sq, diff;
    logic signed [33:0]  nr[3];
    nearest_t res;
    t = 0;
    len = 0;
    dist_sq = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 34'($signed(e[i])) - 34'($signed(s[i]));
      w[i] = 34'($signed(b[i])) - 34'($signed(s[i]));
      t += 128'(d[i]) * 128'(w[i]);
      len += 128'(d[i]) * 128'(d[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (t <= 0) begin
        nr[i] = 34'($signed(s[i]));
      end else if (t >= len) begin
        nr[i] = 34'($signed(e[i]));
      end else begin
        num = 128'(d[i]) * t;
        q = num / len;
        nr[i] = 34'(128'($signed(s[i])) + q);
      end
      diff = 128'($signed(b[i])) - 128'(nr[i]);
      dist_sq += diff * diff;
    end
    res.hit = ({97'd0, rad} * {97'd0, rad}) >= dist_sq;
    res.nx = nr[0][31:0];
    res.ny = nr[1][31:0];
    res.nz = nr[2][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic send_query(logic [31:0] s[3], logic [31:0] e[3], logic [31:0] b[3],
                            logic [30:0] rad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {start_x, start_y, start_z} <= {s[0], s[1], s[2]};
    {end_x, end_y, end_z} <= {e[0], e[1], e[2]};
    {ball_x, ball_y, ball_z} <= {b[0], b[1], b[2]};
    radius <= rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hits.push_back(nearest_point(s, e, b, rad));
  endtask

  function automatic logic [31:0] pick_coord(int spread);
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $urandom_range(2 * spread) - spread;
    endcase
  endfunction

  task automatic send_random(int n, int spread);
    logic [31:0] s[3], e[3], b[3];
    logic [30:0] rad;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        s[i] = pick_coord(spread);
        e[i] = ($urandom_range(9) == 0) ? s[i] : pick_coord(spread);
        b[i] = pick_coord(spread);
      end
      rad = ($urandom_range(3) == 0) ? 31'($urandom()) : 31'($urandom_range(2 * spread));
      send_query(s, e, b, rad);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] z[3], mx[3], mn[3], a[3], c[3], m[3];
    z = '{0, 0, 0};
    mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    a = '{32'h0001_0000, 0, 0};
    c = '{32'h0005_0000, 0, 0};
    m = '{32'h0003_0000, 32'h0002_0000, 0};
    send_query(z, z, z, 31'd0);
    send_query(a, a, c, 31'h0004_0000);
    send_query(a, a, c, 31'h0003_ffff);
    send_query(a, c, m, 31'h0002_0000);
    send_query(a, c, m, 31'h0001_ffff);
    send_query(c, a, m, 31'h0002_0000);
    send_query(a, c, z, 31'h0001_0000);
    send_query(a, c, mx, 31'h7fff_ffff);
    send_query(mn, mx, z, 31'h7fff_ffff);
    send_query(mx, mn, z, 31'd0);
    send_query(mn, mx, mx, 31'd0);
    send_query(mn, mx, mn, 31'h7fff_ffff);
    send_query(mx, mx, mn, 31'h7fff_ffff);
    send_query(mn, mn, mx, 31'h7fff_ffff);
    send_query(mn, mx, '{32'h1234_5678, 32'hfedc_ba98, 32'h0000_0001}, 31'h5555_5555);
    send_query('{32'hffff_ffff, 0, 32'h0000_0001}, '{0, 32'hffff_ffff, 0}, z, 31'd1);
    wait_drained();
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  stall_pct = 0;  send_random(400, 32'h0010_0000);
    send_idle_pct = 59; stall_pct = 0;  send_random(300, 32'h7fff_0000);
    send_idle_pct = 0;  stall_pct = 59; send_random(400, 32'h0000_4000);
    send_idle_pct = 12; stall_pct = 12; send_random(400, 32'h0100_0000);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_output = 1'b1;
    send_random(150, 32'h0002_0000);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_active <= 1'b1;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_active <= 1'b0;
        hold_output = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    nearest_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected transfer", {31'd0, hit}, 0);
      end else begin
        want = pending_hits.pop_front();
        if (hit !== want.hit) report_mismatch("hit", {31'd0, hit}, {31'd0, want.hit});
        if (near_x !== want.nx) report_mismatch("near_x", near_x, want.nx);
        if (near_y !== want.ny) report_mismatch("near_y", near_y, want.ny);
        if (near_z !== want.nz) report_mismatch("near_z", near_z, want.nz);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HOLD_LIMIT) begin
      $display("[segment_sphere_hit_test] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    send_idle_pct = 59;
    send_random(30, 32'h0001_0000);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[segment_sphere_hit_test] OK");
    end else begin
      $display("[segment_sphere_hit_test] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ssht_pkg.sv
rtl/segment_sphere_hit_test.sv
verif/segment_sphere_hit_test_test.sv
